// ===== src/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types, widths and constants of the nearest neighbor tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

  // Largest supported city count and its default.
  localparam int unsigned MaxCitiesDefault = 64;

  // Fixed field widths.
  localparam int unsigned CoordW = 16;
  localparam int unsigned CityW  = 6;
  localparam int unsigned StepW  = 17;
  localparam int unsigned TotalW = 23;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned CmpW   = CityW + 1;

  // Squared distances: one coordinate square, a sum of two, the limit square.
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned D2W    = 2 * StepW;

  // Register reset values.
  localparam logic [CityW-1:0] FirstCityReset = CityW'(2);
  localparam logic [CfgW-1:0]  MaxStepReset   = CfgW'(6000);
  localparam logic [TotalW-1:0] TotalMax      = {TotalW{1'b1}};

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FIRST_CITY = 1'b0,
    CFG_MAX_STEP   = 1'b1
  } cfg_idx_e;

  // Point word as stored in the point memory.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

endpackage

// ===== src/nnt_point_ram.sv =====
// ----------------------------------------------------------------------------
// nnt_point_ram
// Point memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module nnt_point_ram
  import nnt_pkg::*;
#(
  parameter int unsigned Depth = MaxCitiesDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  point_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output point_t                   rdata_o
);

  point_t mem [Depth];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/nnt_isqrt.sv =====
// ----------------------------------------------------------------------------
// nnt_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nnt_isqrt
  import nnt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [D2W-1:0]   radicand_i,
  output logic             done_o,
  output logic [StepW-1:0] root_o
);

  localparam int unsigned Steps = D2W / 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned RemW  = StepW + 1;

  logic [D2W-1:0]   rad_q;
  logic [RemW-1:0]  rem_q;
  logic [StepW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[D2W-1 -: 2]};
    trial  = (RemW+2)'({root_q, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // done rises together with the last bit of the root.
      done_q <= run_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(Steps);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[D2W-3:0], 2'b00};
      rem_q  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[StepW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/nearest_neighbour_tour.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbour_tour
// Greedy nearest neighbor tour over a set of loaded 2-D points.
// ----------------------------------------------------------------------------
// Points are loaded one word per start pulse and take city indexes in arrival
// order. The word with last_point_i set closes the set and runs the tour;
// busy drops in the same cycle that the last result of the tour is shown.
// Each tour step scans every city from first_city up: a visited city is
// skipped, an unvisited one goes through memory read, difference, two
// squarings on the single shared 17 x 17 multiplier and compare, and the
// chosen step then goes through the bit-serial square root unit. Results are
// shown for exactly one cycle with result_valid_o high; the receiver cannot
// stall them, so it must take every result in the cycle it appears.
// Configuration writes are taken at any edge with cfg_we_i high and should
// only be made while busy is low.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour
  import nnt_pkg::*;
#(
  parameter int unsigned MAX_CITIES = MaxCitiesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_addr_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  // Point command.
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic                     last_point_i,
  // Result words.
  output logic                     result_valid_o,
  output logic [CityW-1:0]         city_index_o,
  output logic [StepW-1:0]         step_length_o,
  output logic [TotalW-1:0]        total_length_o,
  output logic                     no_next_city_o,
  output logic                     last_of_tour_o
);

  localparam int unsigned IdxW = $clog2(MAX_CITIES);
  localparam int unsigned CntW = $clog2(MAX_CITIES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR_RD,
    S_CUR_LD,
    S_SCAN,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_CMP,
    S_SCAN_END,
    S_ROOT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [CityW-1:0] first_city_q;
  logic [CfgW-1:0]  max_step_q;

  // Set and tour control.
  logic [CntW-1:0]       cnt_q;
  logic [CntW-1:0]       n_q;
  logic [CntW-1:0]       remaining_q;
  logic [CntW-1:0]       scan_q;
  logic [MAX_CITIES-1:0] visited_q;
  logic [IdxW-1:0]       cur_city_q;
  logic [IdxW-1:0]       best_q;
  logic                  found_q;
  logic [TotalW-1:0]     total_q;

  // Datapath registers.
  logic [CoordW-1:0] cur_x_q, cur_y_q;
  logic [CoordW-1:0] cand_x_q, cand_y_q;
  logic [CoordW-1:0] best_x_q, best_y_q;
  logic [CoordW-1:0] ux_q, uy_q;
  logic [SqW-1:0]    sqx_q, sqy_q;
  logic [D2W-1:0]    limit2_q;
  logic [D2W-1:0]    best2_q;

  // Result registers.
  logic              res_valid_q;
  logic              res_valid_d;
  logic [CityW-1:0]  res_city_q;
  logic [StepW-1:0]  res_step_q;
  logic [TotalW-1:0] res_total_q;
  logic              res_err_q;
  logic              res_last_q;

  // Point memory.
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  point_t          ram_wdata;
  point_t          ram_rdata;

  // Square root unit.
  logic             sqrt_start;
  logic             sqrt_done;
  logic [StepW-1:0] sqrt_root;

  logic accept;
  logic set_full;
  logic [CntW-1:0] n_next;
  logic start_bad;

  logic [StepW-1:0]       mul_a;
  logic [D2W-1:0]         prod;
  logic signed [CoordW:0] dx, dy;
  logic [SumW-1:0]        d2;
  logic [TotalW:0]        total_sum;

  assign accept   = start && !busy;
  assign set_full = cnt_q == CntW'(MAX_CITIES);
  assign n_next   = set_full ? cnt_q : cnt_q + 1'b1;
  // A start city at or beyond the end of the set gives an immediate error word.
  assign start_bad = CmpW'(first_city_q) >= CmpW'(n_next);

  assign ram_we    = accept && !set_full;
  assign ram_wdata = '{x: point_x_i, y: point_y_i};
  assign ram_re    = (state_q == S_CUR_RD) || (state_q == S_SCAN);
  assign ram_raddr = (state_q == S_CUR_RD) ? first_city_q[IdxW-1:0] : scan_q[IdxW-1:0];

  nnt_point_ram #(
    .Depth(MAX_CITIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sqrt_start = (state_q == S_SCAN_END) && found_q;

  nnt_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(best2_q),
    .done_o    (sqrt_done),
    .root_o    (sqrt_root)
  );

  // The one multiplier squares the limit at tour start and both coordinate
  // differences of every candidate.
  always_comb begin
    case (state_q)
      S_CUR_RD: mul_a = max_step_q;
      S_SQX:    mul_a = StepW'(ux_q);
      S_SQY:    mul_a = StepW'(uy_q);
      default:  mul_a = '0;
    endcase
    prod = D2W'(mul_a) * D2W'(mul_a);
  end

  always_comb begin
    dx        = $signed({ram_rdata.x[CoordW-1], ram_rdata.x}) -
                $signed({cur_x_q[CoordW-1], cur_x_q});
    dy        = $signed({ram_rdata.y[CoordW-1], ram_rdata.y}) -
                $signed({cur_y_q[CoordW-1], cur_y_q});
    d2        = SumW'(sqx_q) + SumW'(sqy_q);
    total_sum = (TotalW+1)'(total_q) + (TotalW+1)'(sqrt_root);
  end

  // A result word is shown for one cycle after each of these events: an
  // out-of-range start, the start city, a missing next city, a finished root.
  always_comb begin
    case (state_q)
      S_IDLE:     res_valid_d = accept && last_point_i && start_bad;
      S_CUR_LD:   res_valid_d = 1'b1;
      S_SCAN_END: res_valid_d = !found_q;
      S_ROOT:     res_valid_d = sqrt_done;
      default:    res_valid_d = 1'b0;
    endcase
  end

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_city_q <= FirstCityReset;
      max_step_q   <= MaxStepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FIRST_CITY: first_city_q <= cfg_wdata_i[CityW-1:0];
        CFG_MAX_STEP:   max_step_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Sequencer with its control state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      remaining_q <= '0;
      scan_q      <= '0;
      visited_q   <= '0;
      cur_city_q  <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (last_point_i) begin
              cnt_q     <= '0;
              n_q       <= n_next;
              visited_q <= '0;
              total_q   <= '0;
              if (start_bad) begin
                res_city_q  <= first_city_q;
                res_step_q  <= '0;
                res_total_q <= '0;
                res_err_q   <= 1'b1;
                res_last_q  <= 1'b1;
              end else begin
                cur_city_q  <= first_city_q[IdxW-1:0];
                remaining_q <= n_next - CntW'(first_city_q) - 1'b1;
                state_q     <= S_CUR_RD;
              end
            end else if (!set_full) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_CUR_RD: begin
          // The start city is read here, after its write has settled.
          visited_q[cur_city_q] <= 1'b1;
          limit2_q              <= prod;
          state_q               <= S_CUR_LD;
        end
        S_CUR_LD: begin
          cur_x_q     <= ram_rdata.x;
          cur_y_q     <= ram_rdata.y;
          res_city_q  <= CityW'(cur_city_q);
          res_step_q  <= '0;
          res_total_q <= '0;
          res_err_q   <= 1'b0;
          res_last_q  <= remaining_q == '0;
          scan_q      <= CntW'(first_city_q);
          found_q     <= 1'b0;
          best2_q     <= limit2_q;
          state_q     <= (remaining_q == '0) ? S_IDLE : S_SCAN;
        end
        S_SCAN: begin
          if (scan_q == n_q) begin
            state_q <= S_SCAN_END;
          end else if (visited_q[scan_q[IdxW-1:0]]) begin
            scan_q <= scan_q + 1'b1;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          cand_x_q <= ram_rdata.x;
          cand_y_q <= ram_rdata.y;
          ux_q     <= dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
          uy_q     <= dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
          state_q  <= S_SQX;
        end
        S_SQX: begin
          sqx_q   <= prod[SqW-1:0];
          state_q <= S_SQY;
        end
        S_SQY: begin
          sqy_q   <= prod[SqW-1:0];
          state_q <= S_CMP;
        end
        S_CMP: begin
          // Strictly smaller only, so the lowest index wins a tie.
          if (D2W'(d2) < best2_q) begin
            best2_q  <= D2W'(d2);
            best_q   <= scan_q[IdxW-1:0];
            best_x_q <= cand_x_q;
            best_y_q <= cand_y_q;
            found_q  <= 1'b1;
          end
          scan_q  <= scan_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN_END: begin
          if (found_q) begin
            state_q <= S_ROOT;
          end else begin
            res_city_q  <= CityW'(cur_city_q);
            res_step_q  <= '0;
            res_total_q <= total_q;
            res_err_q   <= 1'b1;
            res_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            total_q               <= total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];
            visited_q[best_q]     <= 1'b1;
            cur_city_q            <= best_q;
            cur_x_q               <= best_x_q;
            cur_y_q               <= best_y_q;
            remaining_q           <= remaining_q - 1'b1;
            res_city_q            <= CityW'(best_q);
            res_step_q            <= sqrt_root;
            res_total_q           <= total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];
            res_err_q             <= 1'b0;
            res_last_q            <= remaining_q == CntW'(1);
            scan_q                <= CntW'(first_city_q);
            found_q               <= 1'b0;
            best2_q               <= limit2_q;
            state_q               <= (remaining_q == CntW'(1)) ? S_IDLE : S_SCAN;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign city_index_o   = res_city_q;
  assign step_length_o  = res_step_q;
  assign total_length_o = res_total_q;
  assign no_next_city_o = res_err_q;
  assign last_of_tour_o = res_last_q;

endmodule

// ===== src/nnt_checker.sv =====
// ----------------------------------------------------------------------------
// nnt_checker
// Port-level checks of the nearest neighbor tour block, bound to its top.
// ----------------------------------------------------------------------------
module nnt_checker
  import nnt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [StepW-1:0]  step_length_o,
  input logic              no_next_city_o,
  input logic              last_of_tour_o
);

  // An error word always closes the tour.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && no_next_city_o |-> last_of_tour_o)
    else $error("error word without last_of_tour");

  // An error word carries no step.
  a_err_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && no_next_city_o |-> step_length_o == '0)
    else $error("error word with nonzero step");

  // The last word of a tour frees the block in the same cycle.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_tour_o |-> !busy)
    else $error("busy after last word of tour");

  // Mid-tour words appear only while the block is busy.
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |-> last_of_tour_o)
    else $error("word shown while idle is not the last of the tour");

  // An idle block with no start stays idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !busy)
    else $error("block became busy without a command");

endmodule

bind nearest_neighbour_tour nnt_checker u_nnt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .step_length_o (step_length_o),
  .no_next_city_o(no_next_city_o),
  .last_of_tour_o(last_of_tour_o)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest neighbor tour block.
// A short table of directed points and register writes comes first. A long run
// of random point sets follows, with the registers changed between some sets. Every
// accepted point goes through a greedy tour planner kept inside the bench. The
// planner lists the result words that the block must show. Each shown word is
// compared, field by field, with the oldest word still listed.
// ----------------------------------------------------------------------------
module tb;
  import nnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCities    = MaxCitiesDefault;
  localparam int unsigned TotalPoints  = 450;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 64;
  // Even if every point went into full sets of 64 cities, the run would stay far
  // below this limit.
  localparam longint      CycleLimit   = 1_000_000;

  typedef logic signed [CoordW-1:0] coord_t;

  // One result word of a tour.
  typedef struct packed {
    logic [CityW-1:0]  city;
    logic [StepW-1:0]  step;
    logic [TotalW-1:0] total;
    logic              no_next;
    logic              last;
  } stop_t;

  typedef enum logic {
    ROW_POINT,
    ROW_REG
  } row_kind_e;

  // One row of the directed table: either a point word or a register write.
  // A point row can carry up to two result words that are easy to work out
  // by hand. Those words replace the planner's words for that row.
  typedef struct packed {
    row_kind_e       kind;
    coord_t          x;
    coord_t          y;
    logic            lp;
    cfg_idx_e        reg_idx;
    logic [CfgW-1:0] reg_val;
    logic [1:0]      n_typed;
    stop_t           t0;
    stop_t           t1;
  } row_t;

  localparam stop_t NoStop    = '0;
  // The start city lies at or past the end of the set.
  localparam stop_t ErrAt2    = '{6'd2, 17'd0, 23'd0, 1'b1, 1'b1};
  localparam stop_t ErrAt63   = '{6'd63, 17'd0, 23'd0, 1'b1, 1'b1};
  // The start city is the only city of the tour.
  localparam stop_t LoneAt2   = '{6'd2, 17'd0, 23'd0, 1'b0, 1'b1};
  // The start word when more cities follow, then the word for no city in reach.
  localparam stop_t OpenAt2   = '{6'd2, 17'd0, 23'd0, 1'b0, 1'b0};
  localparam stop_t StuckAt2  = '{6'd2, 17'd0, 23'd0, 1'b1, 1'b1};
  localparam stop_t OpenAt0   = '{6'd0, 17'd0, 23'd0, 1'b0, 1'b0};
  localparam stop_t StuckAt0  = '{6'd0, 17'd0, 23'd0, 1'b1, 1'b1};

  localparam int unsigned DirectedRows = 24;
  localparam row_t Directed [DirectedRows] = '{
    // After reset the tour starts at city 2, so a one-point set is out of range.
    '{ROW_POINT, 16'sd0, 16'sd0, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd1, ErrAt2, NoStop},
    // Three points, two of them at extreme coordinates. City 2 is alone in the tour.
    '{ROW_POINT, 16'sd100, 16'sd100, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sh8000, 16'sd32767, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd32767, 16'sh8000, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd1, LoneAt2, NoStop},
    // City 3 lies exactly 6000 away. The limit is strict, so the tour is stuck.
    '{ROW_POINT, 16'sd1, 16'sd1, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd2, 16'sd2, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd0, 16'sd0, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd6000, 16'sd0, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd2, OpenAt2, StuckAt2},
    // Start at city 0 with the widest reach.
    '{ROW_REG, 16'sd0, 16'sd0, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_REG, 16'sd0, 16'sd0, 1'b0, CFG_MAX_STEP, 17'd92682, 2'd0, NoStop, NoStop},
    // The four corners. The two nearest corners tie, so the lower index wins.
    '{ROW_POINT, 16'sh8000, 16'sh8000, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd32767, 16'sd32767, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sh8000, 16'sd32767, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd32767, 16'sh8000, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    // A duplicate point (zero step) and a tie at distance 5.
    '{ROW_POINT, 16'sd0, 16'sd0, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd0, 16'sd0, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd3, 16'sd4, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, -16'sd3, -16'sd4, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    // Zero reach: even a duplicate point cannot be reached.
    '{ROW_REG, 16'sd0, 16'sd0, 1'b0, CFG_MAX_STEP, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd5, 16'sd5, 1'b0, CFG_FIRST_CITY, 17'd0, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd5, 16'sd5, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd2, OpenAt0, StuckAt0},
    // Highest start city with a one-point set.
    '{ROW_REG, 16'sd0, 16'sd0, 1'b0, CFG_FIRST_CITY, 17'd63, 2'd0, NoStop, NoStop},
    '{ROW_REG, 16'sd0, 16'sd0, 1'b0, CFG_MAX_STEP, 17'd1, 2'd0, NoStop, NoStop},
    '{ROW_POINT, 16'sd7, 16'sd7, 1'b1, CFG_FIRST_CITY, 17'd0, 2'd1, ErrAt63, NoStop}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_addr_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              start;
  logic              busy;
  coord_t            point_x_i;
  coord_t            point_y_i;
  logic              last_point_i;
  logic              result_valid_o;
  logic [CityW-1:0]  city_index_o;
  logic [StepW-1:0]  step_length_o;
  logic [TotalW-1:0] total_length_o;
  logic              no_next_city_o;
  logic              last_of_tour_o;

  nearest_neighbour_tour #(
    .MAX_CITIES(MaxCities)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .start,
    .busy,
    .point_x_i,
    .point_y_i,
    .last_point_i,
    .result_valid_o,
    .city_index_o,
    .step_length_o,
    .total_length_o,
    .no_next_city_o,
    .last_of_tour_o
  );

  always #4 clk_i = ~clk_i;

  // The bench's own copy of the block's state.
  coord_t            held_x [MaxCities];
  coord_t            held_y [MaxCities];
  int unsigned       held;
  logic [CityW-1:0]  start_city;
  logic [CfgW-1:0]   reach;

  // Words produced by the latest point, and all words not yet shown.
  stop_t             step_stops [$];
  stop_t             planned_stops [$];

  int unsigned       mismatches;
  int unsigned       points_sent;
  int unsigned       idle_max;
  longint            cycles;

  // Appends one word at the tail of a word list.
  function automatic void queue_stop(ref stop_t list [$], input stop_t s);
    list.insert(list.size(), s);
  endfunction

  // Floor square root, found one result bit at a time from the top.
  function automatic logic [StepW-1:0] floor_sqrt(longint unsigned v);
    logic [StepW-1:0] root;
    logic [StepW-1:0] trial;
    longint unsigned  sq;
    root = '0;
    for (int b = StepW - 1; b >= 0; b--) begin
      trial = root | (StepW'(1) << b);
      sq = trial;
      if (sq * sq <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Stores one point. If the point closes the set, plans the whole greedy tour
  // into step_stops.
  function automatic void greedy_tour(coord_t px, coord_t py, logic lp);
    int unsigned       n;
    int unsigned       cur;
    int unsigned       best;
    int unsigned       left;
    int unsigned       sum;
    longint unsigned   lim2;
    longint unsigned   d2;
    longint unsigned   best_d2;
    longint            dx;
    longint            dy;
    logic [StepW-1:0]  root;
    bit                seen [MaxCities];
    bit                found;
    step_stops.delete();
    // Once the store is full, further points are dropped. Their last flag still counts.
    if (held < MaxCities) begin
      held_x[held] = px;
      held_y[held] = py;
      held++;
    end
    if (!lp) begin
      return;
    end
    n = held;
    held = 0;
    if (start_city >= n) begin
      queue_stop(step_stops, stop_t'{start_city, StepW'(0), TotalW'(0), 1'b1, 1'b1});
      return;
    end
    foreach (seen[i]) begin
      seen[i] = 1'b0;
    end
    cur = start_city;
    seen[cur] = 1'b1;
    left = n - cur - 1;
    sum = 0;
    queue_stop(step_stops, stop_t'{CityW'(cur), StepW'(0), TotalW'(0), 1'b0, left == 0});
    lim2 = reach;
    lim2 = lim2 * lim2;
    while (left > 0) begin
      found = 1'b0;
      best = 0;
      best_d2 = lim2;
      // A strict compare keeps the lowest index on a tie.
      for (int unsigned i = start_city; i < n; i++) begin
        if (!seen[i]) begin
          dx = longint'(held_x[i]) - longint'(held_x[cur]);
          dy = longint'(held_y[i]) - longint'(held_y[cur]);
          d2 = dx * dx + dy * dy;
          if (d2 < best_d2) begin
            best_d2 = d2;
            best = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        queue_stop(step_stops, stop_t'{CityW'(cur), StepW'(0), TotalW'(sum), 1'b1, 1'b1});
        return;
      end
      root = floor_sqrt(best_d2);
      sum += root;
      if (sum > TotalMax) begin
        sum = TotalMax;
      end
      cur = best;
      seen[cur] = 1'b1;
      left--;
      queue_stop(step_stops, stop_t'{CityW'(cur), root, TotalW'(sum), 1'b0, left == 0});
    end
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Results cannot be held off, so every strobe is taken at the edge that
  // ends its cycle.
  always @(posedge clk_i) begin : result_check
    stop_t want;
    if (rst_ni && result_valid_o) begin
      if (planned_stops.size() == 0) begin
        $display("%0t: city_index expected no word, actual %0d", $time, city_index_o);
        mismatches++;
      end else begin
        want = planned_stops.pop_front();
        check_field("city_index", want.city, city_index_o);
        check_field("step_length", want.step, step_length_o);
        check_field("total_length", want.total, total_length_o);
        check_field("no_next_city", want.no_next, no_next_city_o);
        check_field("last_of_tour", want.last, last_of_tour_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one point word after a random gap and waits until the block takes
  // it. start stays high from one word to the next when there is no gap.
  task automatic send_point(coord_t px, coord_t py, logic lp, bit use_plan);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    point_x_i    <= px;
    point_y_i    <= py;
    last_point_i <= lp;
    do @(posedge clk_i); while (busy);
    greedy_tour(px, py, lp);
    points_sent++;
    if (use_plan) begin
      foreach (step_stops[i]) begin
        queue_stop(planned_stops, step_stops[i]);
      end
    end
  endtask

  // Waits until every planned word has been shown and busy has dropped.
  task automatic wait_for_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (planned_stops.size() != 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_FIRST_CITY) begin
      start_city = CityW'(val);
    end else begin
      reach = val;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned size;
    int unsigned fc;
    int unsigned ms;
    int unsigned spread;
    int unsigned set_no;
    coord_t      px;
    coord_t      py;
    coord_t      base_x;
    coord_t      base_y;
    bit          scatter;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = CFG_FIRST_CITY;
    cfg_wdata_i  = '0;
    start        = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    last_point_i = 1'b0;
    mismatches   = 0;
    points_sent  = 0;
    cycles       = 0;
    held         = 0;
    start_city   = FirstCityReset;
    reach        = MaxStepReset;
    idle_max     = 8;
    px           = '0;
    py           = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Rows with typed words are checked against those words.
    // All other rows are checked against the planner.
    for (int r = 0; r < DirectedRows; r++) begin
      if (Directed[r].kind == ROW_REG) begin
        wait_for_idle();
        set_reg(Directed[r].reg_idx, Directed[r].reg_val);
      end else begin
        send_point(Directed[r].x, Directed[r].y, Directed[r].lp, Directed[r].n_typed == 0);
        if (Directed[r].n_typed != 0) begin
          queue_stop(planned_stops, Directed[r].t0);
        end
        if (Directed[r].n_typed == 2) begin
          queue_stop(planned_stops, Directed[r].t1);
        end
      end
    end

    // Random sets. Most sets are small. A few fill the store, and some of
    // those overflow it, so that the closing point is dropped but still runs
    // the tour.
    set_no = 0;
    while (points_sent < TotalPoints) begin
      if (set_no == 4) begin
        size = MaxCities + $urandom_range(1, 3);
      end else if ($urandom_range(0, 39) == 0) begin
        size = MaxCities + $urandom_range(0, 2);
      end else begin
        size = $urandom_range(1, 12);
      end

      // Reprogram between some sets, always from an idle block. The other
      // sets follow straight after the previous tour.
      if (set_no % 4 == 0 || $urandom_range(0, 3) == 0) begin
        wait_for_idle();
        case ($urandom_range(0, 5))
          0: fc = 0;
          1: fc = 63;
          2: fc = (size > 63) ? 63 : size;
          3: fc = $urandom_range(0, 63);
          default: fc = $urandom_range(0, (size > 4) ? 3 : size - 1);
        endcase
        set_reg(CFG_FIRST_CITY, CfgW'(fc));
        case ($urandom_range(0, 6))
          0: ms = 0;
          1: ms = 1;
          2: ms = 92682;
          3: ms = 6000;
          4: ms = $urandom_range(0, 92682);
          default: ms = $urandom_range(0, 20000);
        endcase
        set_reg(CFG_MAX_STEP, CfgW'(ms));
      end

      // Some sets send words back to back. The others draw a gap for each word.
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      scatter  = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: spread = 50;
        1: spread = 2000;
        default: spread = 8000;
      endcase
      base_x = CoordW'($urandom);
      base_y = CoordW'($urandom);

      for (int unsigned k = 0; k < size; k++) begin
        // An occasional repeat of the previous point gives zero steps and ties.
        if (k == 0 || $urandom_range(0, 7) != 0) begin
          if (scatter) begin
            px = CoordW'($urandom);
            py = CoordW'($urandom);
          end else begin
            // Cluster around a base point. The sum wraps near the coordinate
            // edges, which throws a few points far away.
            px = base_x + CoordW'($urandom_range(0, 2 * spread)) - CoordW'(spread);
            py = base_y + CoordW'($urandom_range(0, 2 * spread)) - CoordW'(spread);
          end
        end
        send_point(px, py, k == size - 1, 1'b1);
      end
      set_no++;
    end

    wait_for_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/nnt_pkg.sv
src/nnt_point_ram.sv
src/nnt_isqrt.sv
src/nearest_neighbour_tour.sv
src/nnt_checker.sv
tb/tb.sv
